@@ rtl/core/cpau_pkg.sv @@
// ----------------------------------------------------------------------------
// cpau_pkg
// Shared types and constants of the complex polar arithmetic unit: operation
// codes, quadrant codes, CORDIC angle table and gain correction.
// ----------------------------------------------------------------------------
package cpau_pkg;

    // Default configuration
    localparam int COMP_WIDTH_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_POLAR      = 2'd0,
        FUNC_FROM_POLAR = 2'd1,
        FUNC_ADD        = 2'd2,
        FUNC_MUL        = 2'd3
    } func_t;

    // Quadrant base angles: 0, 90, 180 and 270 degrees
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Inverse CORDIC gain, Q0.30
    localparam logic [29:0] GAIN_INV = 30'd652032874;

    // Phase rounding offset at the 16-bit output point
    localparam logic [31:0] PHASE_HALF = 32'h0000_8000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ANGLE_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

@@ rtl/core/cpau_front.sv @@
// ----------------------------------------------------------------------------
// cpau_front
// Input stage: takes items from the input channel, compares the operands
// and packs the item for the queue.
// ----------------------------------------------------------------------------
module cpau_front #(
    parameter int COMP_WIDTH = cpau_pkg::COMP_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic signed [COMP_WIDTH-1:0] a_re,
    input  logic signed [COMP_WIDTH-1:0] a_im,
    input  logic signed [COMP_WIDTH-1:0] b_re,
    input  logic signed [COMP_WIDTH-1:0] b_im,
    input  logic [COMP_WIDTH-1:0]        pol_mag,
    input  logic [15:0]                  pol_phase,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [5*COMP_WIDTH+18:0]     push_data
);
    import cpau_pkg::*;

    localparam int W = COMP_WIDTH;

    typedef struct packed {
        func_t                func;
        logic                 eq;
        logic signed [W-1:0]  a_re;
        logic signed [W-1:0]  a_im;
        logic signed [W-1:0]  b_re;
        logic signed [W-1:0]  b_im;
        logic [W-1:0]         pol_mag;
        logic [15:0]          pol_phase;
    } item_t;

    logic  f_valid_reg;
    item_t f_item_reg;
    item_t f_item_next;
    logic  take;

    assign in_ready = !f_valid_reg || push_ready;
    assign take     = in_valid && in_ready;

    // Classify the incoming item
    always_comb
    begin
        f_item_next.func      = func_t'(func);
        f_item_next.eq        = (a_re == b_re) && (a_im == b_im);
        f_item_next.a_re      = a_re;
        f_item_next.a_im      = a_im;
        f_item_next.b_re      = b_re;
        f_item_next.b_im      = b_im;
        f_item_next.pol_mag   = pol_mag;
        f_item_next.pol_phase = pol_phase;
    end

    // Hold the item until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign push_valid = f_valid_reg;
    assign push_data  = f_item_reg;

endmodule

@@ rtl/core/cpau_queue.sv @@
// ----------------------------------------------------------------------------
// cpau_queue
// Short FIFO between the front and the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module cpau_queue #(
    parameter int DW    = 99,
    parameter int DEPTH = cpau_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);
    import cpau_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    // Store items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/cpau_back.sv @@
// ----------------------------------------------------------------------------
// cpau_back
// Execution pipeline: products, rotating CORDIC for polar construction,
// saturation, then vectoring CORDIC for phase beside a digit-serial square
// root for magnitude, and the output register.
// ----------------------------------------------------------------------------
module cpau_back #(
    parameter int COMP_WIDTH    = cpau_pkg::COMP_WIDTH_DEF,
    parameter int CORDIC_STAGES = cpau_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_take,
    input  logic [5*COMP_WIDTH+18:0]     item_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] res_re,
    output logic signed [COMP_WIDTH-1:0] res_im,
    output logic [COMP_WIDTH:0]          res_mag,
    output logic [15:0]                  res_phase,
    output logic                         overflow,
    output logic                         equal
);
    import cpau_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int F   = W - 4;
    localparam int N   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int VS  = (N > W) ? N : W;
    localparam int RW  = W + 33;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 2;
    localparam int EW  = (RW > CW) ? RW : CW;
    localparam int VW  = 64;
    localparam int VSH = 60 - W;
    localparam int ZW  = 34;
    localparam int SQW = 2 * W + 1;

    localparam logic signed [CW-1:0] MUL_HALF = {{(CW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [RW-1:0] ROT_HALF = {{(RW-30){1'b0}}, 1'b1, 29'd0};
    localparam logic signed [EW-1:0] SAT_HI   = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO   = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        func_t                func;
        logic                 eq;
        logic signed [W-1:0]  a_re;
        logic signed [W-1:0]  a_im;
        logic signed [W-1:0]  b_re;
        logic signed [W-1:0]  b_im;
        logic [W-1:0]         pol_mag;
        logic [15:0]          pol_phase;
    } item_t;

    item_t it;
    logic  adv;

    assign it        = item_t'(item_data);
    assign adv       = !out_valid || out_ready;
    assign item_take = adv && item_valid;

    // ------------------------------------------------------------------
    // Multiply stage
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    func_t                m_func_reg;
    logic                 m_eq_reg;
    logic signed [PW-1:0] m_prr_reg, m_pii_reg, m_pri_reg, m_pir_reg;
    logic signed [W:0]    m_lre_reg, m_lim_reg;
    logic signed [RW-1:0] m_x_reg;
    logic signed [ZW-1:0] m_z_reg;
    logic [1:0]           m_q_reg;

    logic [W+29:0]        gain_prod;
    logic signed [W:0]    lre_next, lim_next;

    // Scale the magnitude and pick the linear operand
    always_comb
    begin
        gain_prod = (W+30)'(it.pol_mag) * (W+30)'(GAIN_INV);
        if (it.func == FUNC_POLAR)
        begin
            lre_next = {it.a_re[W-1], it.a_re};
            lim_next = {it.a_im[W-1], it.a_im};
        end
        else
        begin
            lre_next = {it.a_re[W-1], it.a_re} + {it.b_re[W-1], it.b_re};
            lim_next = {it.a_im[W-1], it.a_im} + {it.b_im[W-1], it.b_im};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_func_reg <= it.func;
            m_eq_reg   <= it.eq;
            m_prr_reg  <= $signed(it.a_re) * $signed(it.b_re);
            m_pii_reg  <= $signed(it.a_im) * $signed(it.b_im);
            m_pri_reg  <= $signed(it.a_re) * $signed(it.b_im);
            m_pir_reg  <= $signed(it.a_im) * $signed(it.b_re);
            m_lre_reg  <= lre_next;
            m_lim_reg  <= lim_next;
            m_x_reg    <= $signed(RW'(gain_prod));
            m_z_reg    <= $signed({{(ZW-30){1'b0}}, it.pol_phase[13:0], 16'h0000});
            m_q_reg    <= it.pol_phase[15:14];
        end
    end

    // ------------------------------------------------------------------
    // Rotation stages
    // ------------------------------------------------------------------
    logic                 r_valid_reg [0:N];
    logic signed [RW-1:0] r_x_reg     [0:N];
    logic signed [RW-1:0] r_y_reg     [0:N];
    logic signed [ZW-1:0] r_z_reg     [0:N];
    logic [1:0]           r_q_reg     [0:N];
    func_t                r_func_reg  [0:N];
    logic                 r_eq_reg    [0:N];
    logic signed [EW-1:0] r_cre_reg   [0:N];
    logic signed [EW-1:0] r_cim_reg   [0:N];

    logic signed [CW-1:0] mul_re_full, mul_im_full, mul_re, mul_im;
    logic signed [EW-1:0] cre_next, cim_next;

    // Round the exact product at the fraction point
    always_comb
    begin
        mul_re_full = CW'(m_prr_reg) - CW'(m_pii_reg) + MUL_HALF;
        mul_im_full = CW'(m_pri_reg) + CW'(m_pir_reg) + MUL_HALF;
        mul_re      = mul_re_full >>> F;
        mul_im      = mul_im_full >>> F;
        if (m_func_reg == FUNC_MUL)
        begin
            cre_next = EW'(mul_re);
            cim_next = EW'(mul_im);
        end
        else
        begin
            cre_next = EW'(m_lre_reg);
            cim_next = EW'(m_lim_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_x_reg[0]    <= m_x_reg;
            r_y_reg[0]    <= '0;
            r_z_reg[0]    <= m_z_reg;
            r_q_reg[0]    <= m_q_reg;
            r_func_reg[0] <= m_func_reg;
            r_eq_reg[0]   <= m_eq_reg;
            r_cre_reg[0]  <= cre_next;
            r_cim_reg[0]  <= cim_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [RW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        logic signed [ZW-1:0] ang;

        // Turn toward zero residual angle
        always_comb
        begin
            ang = $signed({2'b00, ANGLE_TAB[i]});
            if (!r_z_reg[i][ZW-1])
            begin
                x_next = r_x_reg[i] - (r_y_reg[i] >>> i);
                y_next = r_y_reg[i] + (r_x_reg[i] >>> i);
                z_next = r_z_reg[i] - ang;
            end
            else
            begin
                x_next = r_x_reg[i] + (r_y_reg[i] >>> i);
                y_next = r_y_reg[i] - (r_x_reg[i] >>> i);
                z_next = r_z_reg[i] + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_x_reg[i+1]    <= x_next;
                r_y_reg[i+1]    <= y_next;
                r_z_reg[i+1]    <= z_next;
                r_q_reg[i+1]    <= r_q_reg[i];
                r_func_reg[i+1] <= r_func_reg[i];
                r_eq_reg[i+1]   <= r_eq_reg[i];
                r_cre_reg[i+1]  <= r_cre_reg[i];
                r_cim_reg[i+1]  <= r_cim_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Select and saturate stage
    // ------------------------------------------------------------------
    logic                s_valid_reg;
    logic signed [W-1:0] s_re_reg, s_im_reg;
    logic                s_ovf_reg, s_eq_reg;

    logic signed [RW-1:0] qx, qy, rnd_x, rnd_y;
    logic signed [EW-1:0] pick_re, pick_im;
    logic signed [W-1:0]  sat_re, sat_im;
    logic                 ovf_re, ovf_im;

    // Apply quarter turns, round, then clamp to the component range
    always_comb
    begin
        case (quad_t'(r_q_reg[N]))
            QUAD_0:
            begin
                qx = r_x_reg[N];
                qy = r_y_reg[N];
            end
            QUAD_90:
            begin
                qx = -r_y_reg[N];
                qy = r_x_reg[N];
            end
            QUAD_180:
            begin
                qx = -r_x_reg[N];
                qy = -r_y_reg[N];
            end
            default:
            begin
                qx = r_y_reg[N];
                qy = -r_x_reg[N];
            end
        endcase
        rnd_x = (qx + ROT_HALF) >>> 30;
        rnd_y = (qy + ROT_HALF) >>> 30;
        if (r_func_reg[N] == FUNC_FROM_POLAR)
        begin
            pick_re = EW'(rnd_x);
            pick_im = EW'(rnd_y);
        end
        else
        begin
            pick_re = r_cre_reg[N];
            pick_im = r_cim_reg[N];
        end
        ovf_re = (pick_re > SAT_HI) || (pick_re < SAT_LO);
        ovf_im = (pick_im > SAT_HI) || (pick_im < SAT_LO);
        if (pick_re > SAT_HI)
        begin
            sat_re = SAT_HI[W-1:0];
        end
        else if (pick_re < SAT_LO)
        begin
            sat_re = SAT_LO[W-1:0];
        end
        else
        begin
            sat_re = pick_re[W-1:0];
        end
        if (pick_im > SAT_HI)
        begin
            sat_im = SAT_HI[W-1:0];
        end
        else if (pick_im < SAT_LO)
        begin
            sat_im = SAT_LO[W-1:0];
        end
        else
        begin
            sat_im = pick_im[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_re_reg  <= sat_re;
            s_im_reg  <= sat_im;
            s_ovf_reg <= ovf_re || ovf_im;
            s_eq_reg  <= r_eq_reg[N];
        end
    end

    // ------------------------------------------------------------------
    // Vectoring and square-root stages
    // ------------------------------------------------------------------
    logic                 v_valid_reg [0:VS];
    logic signed [VW-1:0] v_x_reg     [0:VS];
    logic signed [VW-1:0] v_y_reg     [0:VS];
    logic signed [ZW-1:0] v_z_reg     [0:VS];
    logic [1:0]           v_q_reg     [0:VS];
    logic                 v_zero_reg  [0:VS];
    logic [SQW-1:0]       v_rem_reg   [0:VS];
    logic [W-1:0]         v_root_reg  [0:VS];
    logic signed [W-1:0]  v_re_reg    [0:VS];
    logic signed [W-1:0]  v_im_reg    [0:VS];
    logic                 v_ovf_reg   [0:VS];
    logic                 v_eq_reg    [0:VS];

    logic signed [PW-1:0] sq_re, sq_im;
    logic signed [W:0]    ext_re, ext_im, vx0, vy0;
    quad_t                q0;
    logic                 re_pos, re_neg, im_pos, im_neg;

    // Square the components and fold the vector into the first quadrant
    always_comb
    begin
        sq_re  = $signed(s_re_reg) * $signed(s_re_reg);
        sq_im  = $signed(s_im_reg) * $signed(s_im_reg);
        ext_re = {s_re_reg[W-1], s_re_reg};
        ext_im = {s_im_reg[W-1], s_im_reg};
        re_neg = s_re_reg[W-1];
        im_neg = s_im_reg[W-1];
        re_pos = !re_neg && (s_re_reg != '0);
        im_pos = !im_neg && (s_im_reg != '0);
        if (re_pos && !im_neg)
        begin
            q0  = QUAD_0;
            vx0 = ext_re;
            vy0 = ext_im;
        end
        else if (!re_pos && im_pos)
        begin
            q0  = QUAD_90;
            vx0 = ext_im;
            vy0 = -ext_re;
        end
        else if (re_neg && !im_pos)
        begin
            q0  = QUAD_180;
            vx0 = -ext_re;
            vy0 = -ext_im;
        end
        else
        begin
            q0  = QUAD_270;
            vx0 = -ext_im;
            vy0 = ext_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_x_reg[0]    <= VW'(vx0) <<< VSH;
            v_y_reg[0]    <= VW'(vy0) <<< VSH;
            v_z_reg[0]    <= '0;
            v_q_reg[0]    <= q0;
            v_zero_reg[0] <= (s_re_reg == '0) && (s_im_reg == '0);
            v_rem_reg[0]  <= {1'b0, sq_re[PW-1:0]} + {1'b0, sq_im[PW-1:0]};
            v_root_reg[0] <= '0;
            v_re_reg[0]   <= s_re_reg;
            v_im_reg[0]   <= s_im_reg;
            v_ovf_reg[0]  <= s_ovf_reg;
            v_eq_reg[0]   <= s_eq_reg;
        end
    end

    for (genvar i = 0; i < VS; i++)
    begin : g_vec
        logic signed [VW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        logic [SQW-1:0]       rem_next;
        logic [W-1:0]         root_next;

        if (i < N)
        begin : g_cor
            logic signed [ZW-1:0] ang;

            // Drive y toward zero, clockwise at y equal to zero
            always_comb
            begin
                ang = $signed({2'b00, ANGLE_TAB[i]});
                if (!v_y_reg[i][VW-1])
                begin
                    x_next = v_x_reg[i] + (v_y_reg[i] >>> i);
                    y_next = v_y_reg[i] - (v_x_reg[i] >>> i);
                    z_next = v_z_reg[i] + ang;
                end
                else
                begin
                    x_next = v_x_reg[i] - (v_y_reg[i] >>> i);
                    y_next = v_y_reg[i] + (v_x_reg[i] >>> i);
                    z_next = v_z_reg[i] - ang;
                end
            end
        end
        else
        begin : g_cor_hold
            always_comb
            begin
                x_next = v_x_reg[i];
                y_next = v_y_reg[i];
                z_next = v_z_reg[i];
            end
        end

        if (i < W)
        begin : g_sq
            localparam int B = W - 1 - i;
            logic [SQW-1:0] trial;

            // Settle one root bit
            always_comb
            begin
                trial = (SQW'(v_root_reg[i]) << (B + 1)) + (SQW'(1) << (2 * B));
                if (v_rem_reg[i] >= trial)
                begin
                    rem_next  = v_rem_reg[i] - trial;
                    root_next = v_root_reg[i] | (W'(1) << B);
                end
                else
                begin
                    rem_next  = v_rem_reg[i];
                    root_next = v_root_reg[i];
                end
            end
        end
        else
        begin : g_sq_hold
            always_comb
            begin
                rem_next  = v_rem_reg[i];
                root_next = v_root_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_x_reg[i+1]    <= x_next;
                v_y_reg[i+1]    <= y_next;
                v_z_reg[i+1]    <= z_next;
                v_q_reg[i+1]    <= v_q_reg[i];
                v_zero_reg[i+1] <= v_zero_reg[i];
                v_rem_reg[i+1]  <= rem_next;
                v_root_reg[i+1] <= root_next;
                v_re_reg[i+1]   <= v_re_reg[i];
                v_im_reg[i+1]   <= v_im_reg[i];
                v_ovf_reg[i+1]  <= v_ovf_reg[i];
                v_eq_reg[i+1]   <= v_eq_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                out_valid_reg;
    logic signed [W-1:0] out_re_reg, out_im_reg;
    logic [W:0]          out_mag_reg, mag_next;
    logic [15:0]         out_phase_reg, phase_next;
    logic                out_ovf_reg, out_eq_reg;
    logic [31:0]         turn_sum;

    // Add the quadrant base, round the phase and the root
    always_comb
    begin
        turn_sum = {v_q_reg[VS], 30'd0} + v_z_reg[VS][31:0] + PHASE_HALF;
        phase_next = v_zero_reg[VS] ? 16'd0 : turn_sum[31:16];
        if (v_rem_reg[VS] > SQW'(v_root_reg[VS]))
        begin
            mag_next = {1'b0, v_root_reg[VS]} + (W+1)'(1);
        end
        else
        begin
            mag_next = {1'b0, v_root_reg[VS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_re_reg    <= v_re_reg[VS];
            out_im_reg    <= v_im_reg[VS];
            out_mag_reg   <= mag_next;
            out_phase_reg <= phase_next;
            out_ovf_reg   <= v_ovf_reg[VS];
            out_eq_reg    <= v_eq_reg[VS];
        end
    end

    // Advance the valid chain as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
            begin
                r_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= VS; k++)
            begin
                v_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            m_valid_reg    <= item_valid;
            r_valid_reg[0] <= m_valid_reg;
            for (int k = 0; k < N; k++)
            begin
                r_valid_reg[k+1] <= r_valid_reg[k];
            end
            s_valid_reg    <= r_valid_reg[N];
            v_valid_reg[0] <= s_valid_reg;
            for (int k = 0; k < VS; k++)
            begin
                v_valid_reg[k+1] <= v_valid_reg[k];
            end
            out_valid_reg <= v_valid_reg[VS];
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = out_re_reg;
    assign res_im    = out_im_reg;
    assign res_mag   = out_mag_reg;
    assign res_phase = out_phase_reg;
    assign overflow  = out_ovf_reg;
    assign equal     = out_eq_reg;

endmodule

@@ rtl/core/complex_polar_arith_unit_core.sv @@
// Throughput: one item per cycle; the back pipeline is fully staged, at most one CORDIC
//   rotation and at most one square-root digit per stage, and stalls only when the
//   output register is held. A four-item queue decouples input from execution.
// Reset: rst_n clears all valid bits and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
// complex_polar_arith_unit_core
// Fixed-point complex arithmetic unit returning results in cartesian and
// polar form, with saturation and operand equality flags.
// ----------------------------------------------------------------------------
module complex_polar_arith_unit_core #(
    parameter int COMP_WIDTH    = cpau_pkg::COMP_WIDTH_DEF,
    parameter int CORDIC_STAGES = cpau_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic signed [COMP_WIDTH-1:0] a_re,
    input  logic signed [COMP_WIDTH-1:0] a_im,
    input  logic signed [COMP_WIDTH-1:0] b_re,
    input  logic signed [COMP_WIDTH-1:0] b_im,
    input  logic [COMP_WIDTH-1:0]        pol_mag,
    input  logic [15:0]                  pol_phase,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] res_re,
    output logic signed [COMP_WIDTH-1:0] res_im,
    output logic [COMP_WIDTH:0]          res_mag,
    output logic [15:0]                  res_phase,
    output logic                         overflow,
    output logic                         equal
);
    import cpau_pkg::*;

    localparam int ITEM_W = 5 * COMP_WIDTH + 19;

    logic              push_valid, push_ready;
    logic [ITEM_W-1:0] push_data;
    logic              pop_valid, pop_ready;
    logic [ITEM_W-1:0] pop_data;

    // Accept and classify
    cpau_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .pol_mag    (pol_mag),
        .pol_phase  (pol_phase),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Buffer items between the two halves
    cpau_queue #(
        .DW    (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Execute
    cpau_back #(
        .COMP_WIDTH    (COMP_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_take  (pop_ready),
        .item_data  (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_re     (res_re),
        .res_im     (res_im),
        .res_mag    (res_mag),
        .res_phase  (res_phase),
        .overflow   (overflow),
        .equal      (equal)
    );

endmodule

@@ rtl/core/cpau_checker.sv @@
// ----------------------------------------------------------------------------
// cpau_checker
// Port-level checks of the complex polar arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module cpau_checker #(
    parameter int COMP_WIDTH = cpau_pkg::COMP_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COMP_WIDTH-1:0] res_re,
    input logic signed [COMP_WIDTH-1:0] res_im,
    input logic [COMP_WIDTH:0]          res_mag,
    input logic [15:0]                  res_phase,
    input logic                         overflow
);
    import cpau_pkg::*;

    localparam logic signed [COMP_WIDTH-1:0] MAX_V = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] MIN_V = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_re) && $stable(res_im)
                                    && $stable(res_mag) && $stable(res_phase))
        else $error("result changed while stalled");

    // Saturation leaves a component at a rail
    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> res_re == MAX_V || res_re == MIN_V
                                  || res_im == MAX_V || res_im == MIN_V)
        else $error("overflow without a saturated component");

    // Zero result has zero magnitude and phase
    a_zero_polar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_re == '0 && res_im == '0 |-> res_mag == '0 && res_phase == '0)
        else $error("zero result with nonzero polar form");

endmodule

bind complex_polar_arith_unit_core cpau_checker #(
    .COMP_WIDTH (COMP_WIDTH)
) u_cpau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_re    (res_re),
    .res_im    (res_im),
    .res_mag   (res_mag),
    .res_phase (res_phase),
    .overflow  (overflow)
);

@@ tb/tb_complex_polar_arith_unit_core.sv @@
// ----------------------------------------------------------------------------
// tb_complex_polar_arith_unit_core
// Self-checking testbench: drives directed and random operand items through
// the valid/ready input, predicts each result with a local fixed-point model
// (sum, exact product, CORDIC polar construction and phase, rounded square
// root) and compares every output item in order, under random idling and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_complex_polar_arith_unit_core;

    import cpau_pkg::*;

    localparam int CW        = 16;
    localparam int STAGES    = 16;
    localparam int FRAC      = CW - 4;
    localparam int VSHIFT    = 60 - CW;
    localparam int N_RANDOM  = 2000;
    localparam int LATENCY   = 6 + STAGES + ((STAGES > CW) ? STAGES : CW);
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        func_t              op;
        logic signed [15:0] ar;
        logic signed [15:0] ai;
        logic signed [15:0] br;
        logic signed [15:0] bi;
        logic [15:0]        mag;
        logic [15:0]        ph;
    } operands_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [16:0]        mag;
        logic [15:0]        ph;
        logic               ovf;
        logic               eq;
    } answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic signed [CW-1:0] a_re, a_im, b_re, b_im;
    logic [CW-1:0]        pol_mag;
    logic [15:0]          pol_phase;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [CW-1:0] res_re, res_im;
    logic [CW:0]          res_mag;
    logic [15:0]          res_phase;
    logic                 overflow;
    logic                 equal;

    operands_t pending_items[$];
    answer_t   expected_answers[$];
    operands_t cur_item;
    int        total_items;
    int        driven_cnt;
    int        answered_cnt;
    int        errors;
    int        cycle_cnt;
    bit        took;
    bit        quiet;
    int        send_gap;
    int        recv_gap;
    int        hold_left;
    bit        hold_done;

    complex_polar_arith_unit_core #(
        .COMP_WIDTH    (CW),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .pol_mag   (pol_mag),
        .pol_phase (pol_phase),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .res_mag   (res_mag),
        .res_phase (res_phase),
        .overflow  (overflow),
        .equal     (equal)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Angle table entry as a signed 64-bit value
    function automatic longint atan_step(int i);
        return longint'({32'd0, ANGLE_TAB[i]});
    endfunction

    // Rounded integer square root
    function automatic longint unsigned root_round(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (v > r)
            r++;
        return r;
    endfunction

    // Vectoring CORDIC phase, quadrant first, zero vector gives zero
    function automatic logic [15:0] vector_phase(longint re, longint im);
        longint          x, y, z, dx, dy;
        longint unsigned q;
        logic [31:0]     t;
        z = 0;
        if (re == 0 && im == 0)
            return 16'd0;
        if (re > 0 && im >= 0)
        begin
            q = QUAD_0;   x = re;  y = im;
        end
        else if (re <= 0 && im > 0)
        begin
            q = QUAD_90;  x = im;  y = -re;
        end
        else if (re < 0 && im <= 0)
        begin
            q = QUAD_180; x = -re; y = -im;
        end
        else
        begin
            q = QUAD_270; x = -im; y = re;
        end
        x = x <<< VSHIFT;
        y = y <<< VSHIFT;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0)
            begin
                x += dy; y -= dx; z += atan_step(i);
            end
            else
            begin
                x -= dy; y += dx; z -= atan_step(i);
            end
        end
        t = 32'((q << 30) + longint'(z) + 64'h8000);
        return t[31:16];
    endfunction

    // Rotating CORDIC for polar construction, then exact quarter turns
    function automatic void rotate_polar(logic [15:0] m, logic [15:0] p,
                                         output longint re, output longint im);
        longint x, y, z, dx, dy, rx, ry;
        x = longint'({48'd0, m}) * longint'({34'd0, GAIN_INV});
        y = 0;
        z = longint'({50'd0, p[13:0]}) <<< 16;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0)
            begin
                x -= dy; y += dx; z -= atan_step(i);
            end
            else
            begin
                x += dy; y -= dx; z += atan_step(i);
            end
        end
        case (p[15:14])
            QUAD_0:   begin rx = x;  ry = y;  end
            QUAD_90:  begin rx = -y; ry = x;  end
            QUAD_180: begin rx = -x; ry = -y; end
            default:  begin rx = y;  ry = -x; end
        endcase
        re = (rx + (longint'(1) <<< 29)) >>> 30;
        im = (ry + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Difference of two products, rounded half up at the fraction point
    function automatic longint scaled_diff(longint p1, longint p2);
        longint lo;
        lo = (p1 & ((longint'(1) <<< FRAC) - 1)) - (p2 & ((longint'(1) <<< FRAC) - 1))
             + (longint'(1) <<< (FRAC - 1));
        return (p1 >>> FRAC) - (p2 >>> FRAC) + (lo >>> FRAC);
    endfunction

    function automatic longint clamp_part(longint v, ref bit ovf);
        if (v > 32767)
        begin
            ovf = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            ovf = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // Predict the result of one item
    function automatic answer_t complex_result(operands_t it);
        answer_t r;
        longint  ar, ai, br, bi, re, im;
        bit      ovf;
        ar  = it.ar;
        ai  = it.ai;
        br  = it.br;
        bi  = it.bi;
        ovf = 1'b0;
        case (it.op)
            FUNC_POLAR:
            begin
                re = ar; im = ai;
            end
            FUNC_FROM_POLAR: rotate_polar(it.mag, it.ph, re, im);
            FUNC_ADD:
            begin
                re = ar + br; im = ai + bi;
            end
            default:
            begin
                re = scaled_diff(ar * br, ai * bi);
                im = scaled_diff(ar * bi, -(ai * br));
            end
        endcase
        re    = clamp_part(re, ovf);
        im    = clamp_part(im, ovf);
        r.re  = 16'(re);
        r.im  = 16'(im);
        r.mag = 17'(root_round(longint'(re * re + im * im)));
        r.ph  = vector_phase(re, im);
        r.ovf = ovf;
        r.eq  = (ar == br) && (ai == bi);
        return r;
    endfunction

    function automatic operands_t make_item(func_t op, int ar, int ai, int br, int bi,
                                            int m, int p);
        operands_t it;
        it.op  = op;
        it.ar  = 16'(ar);
        it.ai  = 16'(ai);
        it.br  = 16'(br);
        it.bi  = 16'(bi);
        it.mag = 16'(m);
        it.ph  = 16'(p);
        return it;
    endfunction

    // One random operand: full range, moderate range, small range or an extreme
    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 5))
            0, 1:    return 16'($urandom);
            2, 3:    return 16'($urandom_range(0, 16384) - 8192);
            4:       return 16'($urandom_range(0, 1024) - 512);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // Build the stimulus and hold reset
    initial
    begin
        operands_t it;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        func      = '0;
        a_re      = '0;
        a_im      = '0;
        b_re      = '0;
        b_im      = '0;
        pol_mag   = '0;
        pol_phase = '0;

        // Directed: extremes, every operation, quadrant edges, saturation
        pending_items.push_back(make_item(FUNC_POLAR, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, 4096, 0, 1, 2, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, 0, 4096, 0, 4096, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, -4096, 0, 3, 3, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, 0, -4096, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, -32768, -32768, 32767, 32767, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, 32767, -1, 32767, -1, 0, 0));
        pending_items.push_back(make_item(FUNC_POLAR, -32768, 32767, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 65535, 0));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 65535, 8192));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 4096, 16384));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 4096, 32768));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 4096, 49152));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 4096, 65535));
        pending_items.push_back(make_item(FUNC_FROM_POLAR, 0, 0, 0, 0, 1, 1));
        pending_items.push_back(make_item(FUNC_ADD, 32767, 32767, 32767, 32767, 0, 0));
        pending_items.push_back(make_item(FUNC_ADD, -32768, -32768, -32768, -1, 0, 0));
        pending_items.push_back(make_item(FUNC_ADD, 4096, -4096, -4096, 4096, 0, 0));
        pending_items.push_back(make_item(FUNC_ADD, 100, 200, 300, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_MUL, -32768, -32768, -32768, -32768, 0, 0));
        pending_items.push_back(make_item(FUNC_MUL, 32767, 32767, 32767, -32768, 0, 0));
        pending_items.push_back(make_item(FUNC_MUL, 4096, 0, 0, 4096, 0, 0));
        pending_items.push_back(make_item(FUNC_MUL, 2048, 1, 1, 2048, 0, 0));
        pending_items.push_back(make_item(FUNC_MUL, 1, -1, 2048, 2048, 0, 0));

        // Random: mostly shaped operands, some equal pairs, some with b_im zero
        for (int n = 0; n < N_RANDOM; n++)
        begin
            it.op  = func_t'($urandom_range(0, 3));
            it.ar  = rand_part();
            it.ai  = rand_part();
            it.br  = rand_part();
            it.bi  = rand_part();
            it.mag = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4096)) : 16'($urandom);
            it.ph  = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                it.br = it.ar;
                it.bi = it.ai;
            end
            else if ($urandom_range(0, 15) == 0)
                it.bi = '0;
            pending_items.push_back(it);
        end
        total_items = pending_items.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Record input acceptance and queue the prediction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_answers.push_back(complex_result(cur_item));
            took = 1'b1;
        end
    end

    // Drive input items, with random idle bursts until the final stretch
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            quiet = (driven_cnt > total_items - 150);
            if (in_valid && !took)
            begin
                // hold the offered item
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_items.size() > 0
                     && (quiet || $urandom_range(0, 9) != 0))
            begin
                cur_item = pending_items.pop_front();
                driven_cnt++;
                in_valid  <= 1'b1;
                func      <= cur_item.op;
                a_re      <= cur_item.ar;
                a_im      <= cur_item.ai;
                b_re      <= cur_item.br;
                b_im      <= cur_item.bi;
                pol_mag   <= cur_item.mag;
                pol_phase <= cur_item.ph;
            end
            else
            begin
                in_valid <= 1'b0;
                if (pending_items.size() > 0)
                    send_gap = $urandom_range(0, 10);
            end
            took = 1'b0;
        end
    end

    // Receiver readiness: random stall bursts outside the final stretch, and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && answered_cnt >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap = $urandom_range(0, 10);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each output item with the oldest prediction
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            answered_cnt++;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected output item re=%0d im=%0d", $time, res_re, res_im);
                errors++;
            end
            else
            begin
                e = expected_answers.pop_front();
                if (res_re !== e.re)
                begin
                    $display("%0t: res_re expected %0d actual %0d", $time, e.re, res_re);
                    errors++;
                end
                if (res_im !== e.im)
                begin
                    $display("%0t: res_im expected %0d actual %0d", $time, e.im, res_im);
                    errors++;
                end
                if (res_mag !== e.mag)
                begin
                    $display("%0t: res_mag expected %0d actual %0d", $time, e.mag, res_mag);
                    errors++;
                end
                if (res_phase !== e.ph)
                begin
                    $display("%0t: res_phase expected %0d actual %0d", $time, e.ph, res_phase);
                    errors++;
                end
                if (overflow !== e.ovf)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow);
                    errors++;
                end
                if (equal !== e.eq)
                begin
                    $display("%0t: equal expected %0b actual %0b", $time, e.eq, equal);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("** complex_polar_arith_unit_core: FAILED **");
            $finish;
        end
    end

    // Wait for drain, let the pipeline settle, then report
    initial
    begin
        wait (rst_n);
        wait (pending_items.size() == 0 && driven_cnt == total_items);
        @(posedge clk);
        while (in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("** complex_polar_arith_unit_core: PASSED **");
        else
            $display("** complex_polar_arith_unit_core: FAILED **");
        $finish;
    end

endmodule
